/* design/crc8fr_pkg.sv */
package crc8fr_pkg;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam int LEN_W = 7;
  localparam int IDX_W = 6;

  // register indexes on the config port (byte address bit 2)
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_MAXPL  = 1'b1;

  localparam logic [7:0] HEADER_RST = 8'hA5;
  localparam logic [LEN_W-1:0] MAXPL_RST = 7'd64;

  typedef struct packed {
    logic ld_cmd;
    logic ld_len;
    logic crc_init;
    logic crc_feed;
    logic wr_data;
    logic clr_cnt;
    logic clr_idx;
    logic idx_inc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hdr_match;
    logic len_ok;
    logic len_zero;
    logic data_done;
    logic crc_match;
    logic slot_free;
    logic idx_last;
  } sts_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* design/crc8fr_ctrl.sv */
module crc8fr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  crc8fr_pkg::sts_t   sts,
  output crc8fr_pkg::cmd_t   cmd
);

  localparam logic [2:0] ST_HUNT   = 3'd0;
  localparam logic [2:0] ST_CMD    = 3'd1;
  localparam logic [2:0] ST_LEN_LO = 3'd2;
  localparam logic [2:0] ST_LEN_HI = 3'd3;
  localparam logic [2:0] ST_DATA   = 3'd4;
  localparam logic [2:0] ST_CHECK  = 3'd5;
  localparam logic [2:0] ST_RD     = 3'd6;
  localparam logic [2:0] ST_LOAD   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       acc;

  assign in_tready = (state_r != ST_RD) && (state_r != ST_LOAD);
  assign acc = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      ST_HUNT: begin
        if (acc && sts.hdr_match) state_nxt = ST_CMD;
      end
      ST_CMD: begin
        if (acc) begin
          cmd.ld_cmd   = 1'b1;
          cmd.crc_init = 1'b1;
          state_nxt    = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        if (acc) begin
          cmd.ld_len   = 1'b1;
          cmd.crc_feed = 1'b1;
          state_nxt    = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        if (acc) begin
          cmd.crc_feed = 1'b1;
          cmd.clr_cnt  = 1'b1;
          if (!sts.len_ok) state_nxt = ST_HUNT;
          else if (sts.len_zero) state_nxt = ST_CHECK;
          else state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        if (acc) begin
          cmd.wr_data  = 1'b1;
          cmd.crc_feed = 1'b1;
          if (sts.data_done) state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (acc) begin
          if (sts.crc_match) begin
            cmd.clr_idx = 1'b1;
            state_nxt   = ST_RD;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_RD: begin
        // memory read of the current index lands next cycle
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          if (sts.idx_last) begin
            state_nxt = ST_HUNT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_RD;
          end
        end
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.slot_free)
    else $error("output loaded while slot busy");

  a_rd_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |=> state_r == ST_LOAD)
    else $error("read state not followed by load");

  a_next_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && sts.slot_free && !sts.idx_last) |=> state_r == ST_RD)
    else $error("burst stopped early");

  a_good_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && acc && sts.crc_match) |=> (state_r == ST_RD && !in_tready))
    else $error("good frame did not start burst");

endmodule

/* design/crc8fr_dp.sv */
module crc8fr_dp #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  crc8fr_pkg::cmd_t                  cmd,
  output crc8fr_pkg::sts_t                  sts,
  input  logic [7:0]                        rx_byte,
  input  logic [7:0]                        header_byte,
  input  logic [crc8fr_pkg::LEN_W-1:0]      limit,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [7:0]                        out_cmd,
  output logic [crc8fr_pkg::LEN_W-1:0]      out_frame_len,
  output logic [7:0]                        out_data_byte,
  output logic [crc8fr_pkg::IDX_W-1:0]      out_byte_index,
  output logic                              out_has_data,
  output logic                              out_last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LW = crc8fr_pkg::LEN_W;

  logic [7:0]    mem [0:MAX_PAYLOAD-1];
  logic [7:0]    rd_data_r;
  logic [7:0]    cmd_r;
  logic [7:0]    len_r;
  logic [LW-1:0] cnt_r;
  logic [LW-1:0] idx_r;
  logic [7:0]    crc_r;
  logic [7:0]    crc_src;
  logic          out_valid_r;
  logic [7:0]    out_cmd_r;
  logic [LW-1:0] out_len_r;
  logic [7:0]    out_data_r;
  logic [crc8fr_pkg::IDX_W-1:0] out_idx_r;
  logic          out_has_r;
  logic          out_last_r;
  logic [LW:0]   cnt_inc;
  logic [LW:0]   idx_inc;

  assign cnt_inc = {1'b0, cnt_r} + 1'b1;
  assign idx_inc = {1'b0, idx_r} + 1'b1;
  assign crc_src = cmd.crc_init ? 8'h00 : crc_r;

  always_comb begin
    sts.hdr_match = (rx_byte == header_byte);
    sts.len_ok    = (rx_byte == 8'h00) && (len_r <= {1'b0, limit});
    sts.len_zero  = (len_r == 8'h00);
    sts.data_done = ({1'b0, cnt_inc} >= {1'b0, len_r});
    sts.crc_match = (rx_byte == crc_r);
    sts.slot_free = !out_valid_r || out_ready;
    sts.idx_last  = ({1'b0, idx_inc} >= {1'b0, len_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_cmd) cmd_r <= rx_byte;
    if (cmd.ld_len) len_r <= rx_byte;
    if (cmd.crc_init || cmd.crc_feed) crc_r <= crc8fr_pkg::crc8_byte(crc_src, rx_byte);
    if (cmd.clr_cnt) cnt_r <= '0;
    else if (cmd.wr_data) cnt_r <= cnt_inc[LW-1:0];
    if (cmd.clr_idx) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_inc[LW-1:0];
  end

  // payload store
  always_ff @(posedge clk) begin
    if (cmd.wr_data) mem[AW'(cnt_r)] <= rx_byte;
    rd_data_r <= mem[AW'(idx_r)];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cmd_r  <= cmd_r;
      out_len_r  <= len_r[LW-1:0];
      out_data_r <= sts.len_zero ? 8'h00 : rd_data_r;
      out_idx_r  <= idx_r[crc8fr_pkg::IDX_W-1:0];
      out_has_r  <= !sts.len_zero;
      out_last_r <= sts.idx_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cmd        = out_cmd_r;
  assign out_frame_len  = out_len_r;
  assign out_data_byte  = out_data_r;
  assign out_byte_index = out_idx_r;
  assign out_has_data   = out_has_r;
  assign out_last       = out_last_r;

endmodule

/* design/crc8_frame_receiver_top.sv */
// Channel   Direction  Transaction                     Fields
// in_       slave      one received byte               tdata[7:0] rx_byte
// out_      master     one payload byte of good frame  tdata, tuser has_data, tlast last
// cfg_      APB slave  register write / read           0x0 header_byte, 0x4 max_payload
//
// Parsing accepts one input byte per cycle; in_tready stays high while a frame is read in.
// After a good check byte the frame drains result by result (registered payload memory
// read, then output load, which waits while the output register is full); in_tready is low
// during that burst. An empty frame gives one result.
// Reset is synchronous on rst_n; the payload memory is not cleared.
// A stalled result holds in the output register; input parsing continues once the burst ends.
module crc8_frame_receiver_top #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] cmd, [14:8] frame_len, [22:15] data_byte,
                                   // [28:23] byte_index, [31:29] zero
  output logic        out_tuser,   // [0] has_data
  output logic        out_tlast,
  // config port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int LW = crc8fr_pkg::LEN_W;
  // effective cap on the length, limited to what the length register can hold
  localparam int LIM_CAP = (MAX_PAYLOAD > 127) ? 127 : MAX_PAYLOAD;

  logic [7:0]    header_byte_r;
  logic [LW-1:0] max_payload_r;
  logic [LW-1:0] limit;
  logic          cfg_wr;

  crc8fr_pkg::cmd_t cmd;
  crc8fr_pkg::sts_t sts;

  logic [7:0]    o_cmd;
  logic [LW-1:0] o_len;
  logic [7:0]    o_data;
  logic [crc8fr_pkg::IDX_W-1:0] o_idx;

  // ---------------- config registers ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_byte_r <= crc8fr_pkg::HEADER_RST;
      max_payload_r <= crc8fr_pkg::MAXPL_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        crc8fr_pkg::REG_HEADER: header_byte_r <= cfg_pwdata[7:0];
        crc8fr_pkg::REG_MAXPL:  max_payload_r <= cfg_pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      crc8fr_pkg::REG_HEADER: cfg_prdata = {24'h0, header_byte_r};
      crc8fr_pkg::REG_MAXPL:  cfg_prdata = {{(32-LW){1'b0}}, max_payload_r};
      default:                cfg_prdata = 32'h0;
    endcase
  end

  // length limit: smaller of the register and the store depth
  assign limit = (max_payload_r > LW'(LIM_CAP)) ? LW'(LIM_CAP) : max_payload_r;

  // ---------------- controller ----------------
  crc8fr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // ---------------- datapath ----------------
  crc8fr_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .rx_byte        (in_tdata),
    .header_byte    (header_byte_r),
    .limit          (limit),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_cmd        (o_cmd),
    .out_frame_len  (o_len),
    .out_data_byte  (o_data),
    .out_byte_index (o_idx),
    .out_has_data   (out_tuser),
    .out_last       (out_tlast)
  );

  assign out_tdata = {3'b000, o_idx, o_data, o_len, o_cmd};

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int CLK_HALF = 6;
  localparam int CLK_PERIOD = 2 * CLK_HALF;
  localparam int PL_DEPTH = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int PRINT_CAP = 50;
  localparam int LEN_W = crc8fr_pkg::LEN_W;
  localparam int IDX_W = crc8fr_pkg::IDX_W;

  // register byte addresses: register index sits on address bit 2
  localparam logic [2:0] ADDR_HEADER = {crc8fr_pkg::REG_HEADER, 2'b00};
  localparam logic [2:0] ADDR_MAXPL  = {crc8fr_pkg::REG_MAXPL, 2'b00};

  // parser phases of the predictor
  typedef enum logic [2:0] {
    HUNT       = 3'd0,
    GET_CMD    = 3'd1,
    GET_LEN_LO = 3'd2,
    GET_LEN_HI = 3'd3,
    GET_DATA   = 3'd4,
    GET_CHECK  = 3'd5
  } parse_phase_t;

  // payload pattern used when building a frame
  typedef enum int {
    FILL_RANDOM  = 0,
    FILL_EXTREME = 1
  } fill_t;

  // one result transaction, field by field
  typedef struct packed {
    logic [7:0]       cmd;
    logic [LEN_W-1:0] frame_len;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] byte_index;
    logic             has_data;
    logic             last;
  } beat_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;     // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;            // [7:0] cmd, [14:8] frame_len, [22:15] data_byte,
                                     // [28:23] byte_index, [31:29] zero
  logic        out_tuser;            // [0] has_data
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  crc8_frame_receiver_top #(
    .MAX_PAYLOAD(PL_DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // Testbench state
  // ---------------------------------------------------------------------------
  logic [7:0] rx_backlog[$];         // bytes waiting for the driver
  beat_t      beats_due[$];          // predicted result transactions, oldest first

  int send_idle_pct = 0;             // chance the sender leaves a cycle empty
  int stall_pct = 0;                 // chance the receiver drops tready
  logic hold_go = 1'b0;              // kicks off the long receiver hold-off
  logic long_hold = 1'b0;
  logic in_fire = 1'b0;              // input transaction seen at the last rising edge

  int bytes_queued = 0;
  int bytes_taken = 0;
  int beats_seen = 0;
  int err_count = 0;
  int frames_good = 0;
  int frames_empty = 0;
  int frames_bad_crc = 0;
  int frames_too_long = 0;
  int settings_used = 1;

  // predictor copy of the registers and the parser (reset values)
  logic [7:0]       hdr_q = crc8fr_pkg::HEADER_RST;
  logic [LEN_W-1:0] maxpl_q = crc8fr_pkg::MAXPL_RST;
  parse_phase_t     phase_q = HUNT;
  logic [7:0]       cmd_q = 8'h00;
  logic [15:0]      len_q = 16'h0000;
  int               cnt_q = 0;
  logic [7:0]       crc_q = 8'h00;
  logic [7:0]       store_q[PL_DEPTH];

  initial begin
    foreach (store_q[i]) store_q[i] = 8'h00;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // CRC-8, poly 0x07, MSB first, no reflection, no final xor
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ crc8fr_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // effective payload limit: register clamped to the store depth
  function automatic int payload_limit();
    return (int'(maxpl_q) > PL_DEPTH) ? PL_DEPTH : int'(maxpl_q);
  endfunction

  // advance the parser by one accepted byte; a good check byte releases the frame
  task automatic parse_byte(input logic [7:0] b);
    int n;
    beat_t bt;
    case (phase_q)
      GET_CMD: begin
        cmd_q = b;
        crc_q = crc8_step(8'h00, b);
        phase_q = GET_LEN_LO;
      end
      GET_LEN_LO: begin
        len_q = {8'h00, b};
        crc_q = crc8_step(crc_q, b);
        phase_q = GET_LEN_HI;
      end
      GET_LEN_HI: begin
        len_q[15:8] = b;
        crc_q = crc8_step(crc_q, b);
        if (int'(len_q) > payload_limit()) begin
          // oversize: drop and hunt again, no result
          phase_q = HUNT;
          frames_too_long++;
        end else begin
          cnt_q = 0;
          phase_q = (len_q != 16'h0) ? GET_DATA : GET_CHECK;
        end
      end
      GET_DATA: begin
        // header value inside the payload is plain data
        if (cnt_q < PL_DEPTH) store_q[cnt_q] = b;
        crc_q = crc8_step(crc_q, b);
        cnt_q++;
        if (cnt_q >= int'(len_q)) phase_q = GET_CHECK;
      end
      GET_CHECK: begin
        phase_q = HUNT;
        if (b != crc_q) begin
          frames_bad_crc++;
        end else begin
          frames_good++;
          n = (int'(len_q) > PL_DEPTH) ? PL_DEPTH : int'(len_q);
          if (n == 0) begin
            // empty frame: a single marker transaction without data
            frames_empty++;
            bt = '{cmd: cmd_q, frame_len: '0, data_byte: 8'h00, byte_index: '0,
                   has_data: 1'b0, last: 1'b1};
            beats_due.push_back(bt);
          end else begin
            for (int i = 0; i < n; i++) begin
              bt = '{cmd: cmd_q, frame_len: LEN_W'(n), data_byte: store_q[i],
                     byte_index: IDX_W'(i), has_data: 1'b1, last: (i == n - 1)};
              beats_due.push_back(bt);
            end
          end
        end
      end
      // hunting, and any unused phase code
      default: phase_q = (b == hdr_q) ? GET_CMD : HUNT;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(input string msg);
    if (err_count < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_beat();
    beat_t want;
    beat_t got;
    got = '{cmd: out_tdata[7:0], frame_len: out_tdata[14:8], data_byte: out_tdata[22:15],
            byte_index: out_tdata[28:23], has_data: out_tuser, last: out_tlast};
    beats_seen++;
    if (beats_due.size() == 0) begin
      log_mismatch($sformatf("result with nothing expected, tdata=%h tuser=%b tlast=%b",
                             out_tdata, out_tuser, out_tlast));
    end else begin
      want = beats_due.pop_front();
      if (got.cmd !== want.cmd)
        log_mismatch($sformatf("cmd %h, expected %h", got.cmd, want.cmd));
      if (got.frame_len !== want.frame_len)
        log_mismatch($sformatf("frame_len %0d, expected %0d", got.frame_len, want.frame_len));
      if (got.data_byte !== want.data_byte)
        log_mismatch($sformatf("data_byte %h, expected %h (index %0d)",
                               got.data_byte, want.data_byte, want.byte_index));
      if (got.byte_index !== want.byte_index)
        log_mismatch($sformatf("byte_index %0d, expected %0d", got.byte_index,
                               want.byte_index));
      if (got.has_data !== want.has_data)
        log_mismatch($sformatf("has_data %b, expected %b", got.has_data, want.has_data));
      if (got.last !== want.last)
        log_mismatch($sformatf("last %b, expected %b", got.last, want.last));
      if (out_tdata[31:29] !== 3'b000)
        log_mismatch($sformatf("tdata pad bits %b not zero", out_tdata[31:29]));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents backlog bytes, changes only at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      // free to move on: offer the next byte unless this cycle is left idle
      if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= rx_backlog.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure; the long hold-off overrides random stalls
  always @(negedge clk) begin
    if (long_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // hold-off process: receiver stays off long enough that the block stalls its input
  initial begin
    wait (hold_go);
    @(negedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    long_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata);
        bytes_taken++;
      end
      if (out_tvalid && out_tready) check_beat();
    end
  end

  // ---------------------------------------------------------------------------
  // Config port: setup cycle then access cycle, pready is always high
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic cfg_read(input logic [2:0] addr, output logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= addr;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    val = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // write both registers, mirror the kept low bits, read them back
  task automatic set_regs(input logic [31:0] hdr_word, input logic [31:0] maxpl_word);
    logic [31:0] rd;
    cfg_write(ADDR_HEADER, hdr_word);
    hdr_q = hdr_word[7:0];
    cfg_write(ADDR_MAXPL, maxpl_word);
    maxpl_q = maxpl_word[LEN_W-1:0];
    settings_used++;
    cfg_read(ADDR_HEADER, rd);
    if (rd !== {24'h0, hdr_q})
      log_mismatch($sformatf("header_byte reads %h, expected %h", rd, hdr_q));
    cfg_read(ADDR_MAXPL, rd);
    if (rd !== {{(32 - LEN_W){1'b0}}, maxpl_q})
      log_mismatch($sformatf("max_payload reads %h, expected %h", rd, maxpl_q));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    rx_backlog.push_back(b);
    bytes_queued++;
  endtask

  // one framed transaction sequence; keep < 0 sends it whole, else only the first bytes
  task automatic queue_frame(input logic [7:0] cmd, input logic [15:0] len,
                             input logic good_crc, input fill_t fill, input int keep);
    logic [7:0] bytes[$];
    logic [7:0] crc;
    logic [7:0] b;
    bytes.push_back(hdr_q);
    bytes.push_back(cmd);
    bytes.push_back(len[7:0]);
    bytes.push_back(len[15:8]);
    crc = crc8_step(8'h00, cmd);
    crc = crc8_step(crc, len[7:0]);
    crc = crc8_step(crc, len[15:8]);
    // oversize lengths end at the length field, the block hunts again
    if (int'(len) <= payload_limit()) begin
      for (int i = 0; i < int'(len); i++) begin
        if (fill == FILL_EXTREME) begin
          b = (i % 3 == 0) ? hdr_q : ((i % 3 == 1) ? 8'hFF : 8'h00);
        end else begin
          // header value mixed into the payload now and then
          b = ($urandom_range(15) == 0) ? hdr_q : 8'($urandom);
        end
        bytes.push_back(b);
        crc = crc8_step(crc, b);
      end
      bytes.push_back(good_crc ? crc : (crc ^ (8'h01 << $urandom_range(7))));
    end
    if (keep >= 0 && keep < bytes.size()) bytes = bytes[0:keep-1];
    foreach (bytes[i]) push_byte(bytes[i]);
  endtask

  // random traffic, mostly well formed frames; first_len >= 0 forces one frame length
  task automatic run_random(input int nbytes, input int first_len);
    int start;
    int lim;
    int kind;
    logic [15:0] len;
    start = bytes_queued;
    lim = payload_limit();
    if (first_len >= 0) queue_frame(8'($urandom), 16'(first_len), 1'b1, FILL_RANDOM, -1);
    while (bytes_queued - start < nbytes) begin
      kind = $urandom_range(99);
      // short payloads mostly, the full range now and then
      len = ($urandom_range(7) == 0) ? 16'($urandom_range(lim, 0))
                                     : 16'($urandom_range((lim < 8) ? lim : 8, 0));
      if (kind < 70) begin
        queue_frame(8'($urandom), len, 1'b1, FILL_RANDOM, -1);
      end else if (kind < 80) begin
        queue_frame(8'($urandom), len, 1'b0, FILL_RANDOM, -1);
      end else if (kind < 88) begin
        len = $urandom_range(1) ? 16'(lim + 1) : 16'($urandom_range(16'hFFFF, lim + 1));
        queue_frame(8'($urandom), len, 1'b1, FILL_RANDOM, -1);
      end else if (kind < 94) begin
        repeat ($urandom_range(4, 1)) push_byte(8'($urandom));
      end else begin
        // broken frame: cut off after a few bytes
        queue_frame(8'($urandom), len, 1'b1, FILL_RANDOM, $urandom_range(4, 1));
      end
    end
  endtask

  // all bytes taken and all results in, then a short settle before touching registers
  task automatic wait_idle();
    while (bytes_taken != bytes_queued || beats_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // directed: reset settings (header 0xA5, limit 64), no idling
    push_byte(8'h00);                                          // noise while hunting
    queue_frame(8'h00, 16'd0, 1'b1, FILL_RANDOM, -1);          // empty frame
    queue_frame(8'hFF, 16'd3, 1'b1, FILL_EXTREME, -1);         // header byte as data
    queue_frame(8'h12, 16'd1, 1'b0, FILL_RANDOM, -1);          // bad check byte
    queue_frame(8'h01, 16'd65, 1'b1, FILL_RANDOM, -1);         // one past the limit
    queue_frame(8'h7E, 16'hFF00, 1'b1, FILL_RANDOM, -1);       // high length byte set
    queue_frame(8'h80, 16'd2, 1'b1, FILL_RANDOM, -1);          // recovers after drops
    wait_idle();

    // phase 1: full limit, no idling, long receiver hold-off fills the block
    set_regs(32'h0000_00A5, 32'd64);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b1;
    run_random(100, 64);
    wait_idle();

    // phase 2: header 0x00, limit 0 (upper bits dropped): only empty frames pass
    set_regs(32'hC3C3_C300, 32'hFFFF_FF80);
    send_idle_pct = 57;
    stall_pct = 0;
    run_random(100, 0);
    wait_idle();

    // phase 3: header 0xFF, register above the store depth, limit clamps to 64
    set_regs(32'h1234_56FF, 32'd127);
    send_idle_pct = 0;
    stall_pct = 57;
    run_random(100, 64);
    wait_idle();

    // phase 4: limit 1, both sides idle now and then
    set_regs(32'h0000_003C, 32'd1);
    send_idle_pct = 17;
    stall_pct = 17;
    run_random(100, 1);
    wait_idle();

    // phase 5: odd limit, both sides idle
    set_regs(32'h0000_005A, 32'd13);
    send_idle_pct = 17;
    stall_pct = 17;
    run_random(100, 13);
    wait_idle();

    $display("Covered %0d input bytes: %0d frames passed (%0d empty), %0d CRC drops, %0d oversize",
             bytes_taken, frames_good, frames_empty, frames_bad_crc, frames_too_long);
    $display("Compared %0d result transactions across %0d register settings, %0d mismatches",
             beats_seen, settings_used, err_count);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(CLK_PERIOD * 400_000);
    $display("Timeout with %0d results still expected", beats_due.size());
    $display("Verification failed");
    $finish;
  end

endmodule
